FILE: hw/rtl/qrm_pkg.sv
// Shared types and constants for the quaternion to rotation matrix block.
`default_nettype none
package qrm_pkg;
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = DATA_WIDTH - 2;
	localparam int PROD_W     = 2 * DATA_WIDTH;      // signed product
	localparam int NUM_W      = 2 * DATA_WIDTH + 1;  // magnitudes and norm
	localparam int SUM_W      = NUM_W + 1;           // signed sums
	localparam int DIV_LAT    = FRAC_BITS + 2;       // divider lane depth

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_w;
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m00;
		logic signed [DATA_WIDTH-1:0] m01;
		logic signed [DATA_WIDTH-1:0] m02;
		logic signed [DATA_WIDTH-1:0] m10;
		logic signed [DATA_WIDTH-1:0] m11;
		logic signed [DATA_WIDTH-1:0] m12;
		logic signed [DATA_WIDTH-1:0] m20;
		logic signed [DATA_WIDTH-1:0] m21;
		logic signed [DATA_WIDTH-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] mag;
		logic [NUM_W-1:0] den;
	} div_in_t;

	function automatic div_in_t make_div(logic signed [SUM_W-1:0] num,
			logic [NUM_W-1:0] den);
		div_in_t d;
		logic signed [SUM_W-1:0] a;
		a     = num[SUM_W-1] ? -num : num;
		d.neg = num[SUM_W-1];
		d.mag = a[NUM_W-1:0];
		d.den = den;
		return d;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/qrm_div.sv
// Pipelined restoring divider lane: round(mag * 2^FRAC / den) with sign.
`default_nettype none
module qrm_div (
	input  logic                                 clk,
	input  qrm_pkg::div_in_t                     din,
	output logic signed [qrm_pkg::DATA_WIDTH-1:0] quo
);
	import qrm_pkg::*;

	logic [NUM_W-1:0]     rem_s [0:FRAC_BITS];
	logic [NUM_W-1:0]     den_s [0:FRAC_BITS];
	logic [FRAC_BITS:0]   quo_s [0:FRAC_BITS];
	logic                 neg_s [0:FRAC_BITS];

	// integer bit: set when |num| is at least den
	always_ff @(posedge clk) begin
		if (din.mag >= din.den) begin
			rem_s[0] <= din.mag - din.den;
			quo_s[0] <= (FRAC_BITS+1)'(1);
		end else begin
			rem_s[0] <= din.mag;
			quo_s[0] <= '0;
		end
		den_s[0] <= din.den;
		neg_s[0] <= din.neg;
	end

	// one fraction bit per stage
	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
		logic [NUM_W:0] sh;
		logic           ge;
		assign sh = {rem_s[k-1], 1'b0};
		assign ge = sh >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (ge) begin
				rem_s[k] <= NUM_W'(sh - {1'b0, den_s[k-1]});
			end else begin
				rem_s[k] <= sh[NUM_W-1:0];
			end
			quo_s[k] <= {quo_s[k-1][FRAC_BITS-1:0], ge};
			den_s[k] <= den_s[k-1];
			neg_s[k] <= neg_s[k-1];
		end
	end

	// round half away from zero on magnitude, then apply sign
	logic                  rnd;
	logic [DATA_WIDTH-1:0] qr;
	assign rnd = {rem_s[FRAC_BITS], 1'b0} >= {1'b0, den_s[FRAC_BITS]};
	assign qr  = DATA_WIDTH'({1'b0, quo_s[FRAC_BITS]}) + DATA_WIDTH'(rnd);

	always_ff @(posedge clk) begin
		quo <= neg_s[FRAC_BITS] ? -signed'(qr) : signed'(qr);
	end
endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_to_rotation_matrix.sv
// Top level: quaternion (w, x, y, z) in, 3x3 rotation matrix out.
//
// Usage: drive quat and pulse start; busy is always low, so an item is taken
// on every clock edge with start high and a new quaternion may follow every
// cycle. All nine entries of the matrix appear on mat at once, with done high
// for exactly one cycle.
// Throughput: one item per cycle. The depth is set by the divider lanes, one
// quotient bit per stage: 2 front stages (products, then sums and the norm),
// FRAC_BITS+2 divider stages, and the output register.
// Format: signed Q1.14 in and out; every entry is the exact ratio over the
// norm w^2+x^2+y^2+z^2, rounded to nearest (ties away from zero).
// A zero quaternion yields the identity matrix.
// Reset: clears the valid chain only, so no stray done after reset; data
// registers are not reset.
// The receiver cannot stall, so there is no back-pressure anywhere.
`default_nettype none
module quaternion_to_rotation_matrix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  qrm_pkg::quat_t quat,
	output logic           done,
	output qrm_pkg::mat_t  mat
);
	import qrm_pkg::*;

	assign busy = 1'b0;

	// stage 1: the ten products
	logic signed [PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PROD_W-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic                     vld_s1;

	always_ff @(posedge clk) begin
		ww_s1 <= quat.quat_w * quat.quat_w;
		xx_s1 <= quat.quat_x * quat.quat_x;
		yy_s1 <= quat.quat_y * quat.quat_y;
		zz_s1 <= quat.quat_z * quat.quat_z;
		xy_s1 <= quat.quat_x * quat.quat_y;
		wz_s1 <= quat.quat_w * quat.quat_z;
		xz_s1 <= quat.quat_x * quat.quat_z;
		wy_s1 <= quat.quat_w * quat.quat_y;
		yz_s1 <= quat.quat_y * quat.quat_z;
		wx_s1 <= quat.quat_w * quat.quat_x;
	end

	// stage 2: numerators as sign/magnitude, the norm and the zero flag
	logic signed [SUM_W-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
	logic [NUM_W-1:0]        n2;
	assign ww = SUM_W'(ww_s1);
	assign xx = SUM_W'(xx_s1);
	assign yy = SUM_W'(yy_s1);
	assign zz = SUM_W'(zz_s1);
	assign xy = SUM_W'(xy_s1);
	assign wz = SUM_W'(wz_s1);
	assign xz = SUM_W'(xz_s1);
	assign wy = SUM_W'(wy_s1);
	assign yz = SUM_W'(yz_s1);
	assign wx = SUM_W'(wx_s1);
	assign n2 = NUM_W'(ww + xx + yy + zz);

	div_in_t div_s2 [0:8];
	logic    zero_s2;
	logic    vld_s2;

	always_ff @(posedge clk) begin
		div_s2[0] <= make_div((ww + xx) - (yy + zz), n2);
		div_s2[1] <= make_div((xy - wz) <<< 1, n2);
		div_s2[2] <= make_div((xz + wy) <<< 1, n2);
		div_s2[3] <= make_div((xy + wz) <<< 1, n2);
		div_s2[4] <= make_div((ww + yy) - (xx + zz), n2);
		div_s2[5] <= make_div((yz - wx) <<< 1, n2);
		div_s2[6] <= make_div((xz - wy) <<< 1, n2);
		div_s2[7] <= make_div((yz + wx) <<< 1, n2);
		div_s2[8] <= make_div((ww + zz) - (xx + yy), n2);
		zero_s2   <= (n2 == '0);
	end

	// nine divider lanes
	logic signed [DATA_WIDTH-1:0] q [0:8];
	for (genvar i = 0; i < 9; i++) begin : g_lane
		qrm_div u_div (
			.clk (clk),
			.din (div_s2[i]),
			.quo (q[i])
		);
	end

	// valid and zero flag travel alongside the lanes
	logic [DIV_LAT-1:0] vld_pipe_q;
	logic [DIV_LAT-1:0] zero_pipe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_pipe_q <= '0;
			done       <= 1'b0;
		end else begin
			vld_s1     <= start;
			vld_s2     <= vld_s1;
			vld_pipe_q <= {vld_pipe_q[DIV_LAT-2:0], vld_s2};
			done       <= vld_pipe_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		zero_pipe_q <= {zero_pipe_q[DIV_LAT-2:0], zero_s2};
	end

	// output register; zero norm forces the identity
	localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) <<< FRAC_BITS;
	logic zf;
	assign zf = zero_pipe_q[DIV_LAT-1];

	always_ff @(posedge clk) begin
		mat.m00 <= zf ? ONE : q[0];
		mat.m01 <= zf ? '0  : q[1];
		mat.m02 <= zf ? '0  : q[2];
		mat.m10 <= zf ? '0  : q[3];
		mat.m11 <= zf ? ONE : q[4];
		mat.m12 <= zf ? '0  : q[5];
		mat.m20 <= zf ? '0  : q[6];
		mat.m21 <= zf ? '0  : q[7];
		mat.m22 <= zf ? ONE : q[8];
	end
endmodule
`default_nettype wire
